### sv/rational_arith_reduce_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic reduce unit
// Short forms for clocked properties on clk with the asynchronous reset
// rst_n disabling the check.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_REDUCE_UNIT_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rar: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define RAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rar: next-cycle property violated");

`endif

### sv/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Shared widths, operation codes, datapath commands and status for the
// rational arithmetic reduce unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rar_pkg;

    // Numerator width; denominators use one bit less.
    localparam int OPERAND_BITS = 16;
    localparam int DEN_BITS     = OPERAND_BITS - 1;
    // Raw products and sums fit in twice the operand width.
    localparam int MAG_W        = 2 * OPERAND_BITS;
    localparam int CNT_W        = $clog2(MAG_W);
    // Width used for the saturation compares.
    localparam int EXT_W        = ((MAG_W > 32) ? MAG_W : 32) + 1;
    localparam int RES_NUM_W    = 32;
    localparam int RES_DEN_W    = 31;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_COMBINE,
        DP_SET_ERR,
        DP_SET_ZERO,
        DP_GCD_INIT,
        DP_GCD_TZ,
        DP_GCD_U,
        DP_GCD_STEP,
        DP_GCD_FIX,
        DP_DIV_NUM,
        DP_DIV_DEN,
        DP_DIV_STEP,
        DP_STORE_QN,
        DP_STORE_QD,
        DP_PUSH
    } dp_op_t;

    typedef struct packed {
        logic dm_zero;
        logic nm_zero;
        logic both_even;
        logic u_even;
        logic v_zero;
        logic div_last;
    } dp_stat_t;

endpackage

`default_nettype wire

### sv/rar_datapath.sv
// ----------------------------------------------------------------------------
// rar_datapath
// Operand registers, shared multiplier, sign-magnitude combine, binary gcd
// and a restoring divider, all stepped by commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_datapath (
    input  wire logic                                     clk,
    input  wire rar_pkg::dp_op_t                          ctrl_op,
    output rar_pkg::dp_stat_t                             dp_stat,
    input  wire logic [1:0]                               cmd,
    input  wire logic signed [rar_pkg::OPERAND_BITS-1:0]  num_first,
    input  wire logic [rar_pkg::DEN_BITS-1:0]             den_first,
    input  wire logic signed [rar_pkg::OPERAND_BITS-1:0]  num_second,
    input  wire logic [rar_pkg::DEN_BITS-1:0]             den_second,
    output logic signed [rar_pkg::RES_NUM_W-1:0]          res_num,
    output logic [rar_pkg::RES_DEN_W-1:0]                 res_den,
    output logic                                          div_zero
);

    localparam int OB = rar_pkg::OPERAND_BITS;
    localparam int MW = rar_pkg::MAG_W;
    localparam int EW = rar_pkg::EXT_W;
    localparam int CW = rar_pkg::CNT_W;

    localparam logic [EW-1:0] NEG_LIM = EW'(64'h8000_0000);
    localparam logic [EW-1:0] POS_LIM = EW'(64'h7FFF_FFFF);

    // Operand registers.
    rar_pkg::op_t    op_reg,  op_next;
    logic [OB-1:0]   am_reg,  am_next;
    logic [OB-1:0]   cm_reg,  cm_next;
    logic [OB-1:0]   b_reg,   b_next;
    logic [OB-1:0]   d_reg,   d_next;
    logic            an_reg,  an_next;
    logic            cn_reg,  cn_next;
    // Products and raw fraction.
    logic [MW-1:0]   p0_reg,  p0_next;
    logic [MW-1:0]   p1_reg,  p1_next;
    logic [MW-1:0]   p2_reg,  p2_next;
    logic [MW-1:0]   nm_reg,  nm_next;
    logic [MW-1:0]   dm_reg,  dm_next;
    logic            neg_reg, neg_next;
    // Gcd state.
    logic [MW-1:0]   u_reg,   u_next;
    logic [MW-1:0]   v_reg,   v_next;
    logic [CW-1:0]   k_reg,   k_next;
    logic [MW-1:0]   g_reg,   g_next;
    // Divider state.
    logic [MW-1:0]   rem_reg, rem_next;
    logic [MW-1:0]   sh_reg,  sh_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [MW-1:0]   qn_reg,  qn_next;
    logic [MW-1:0]   qd_reg,  qd_next;
    logic            err_reg, err_next;
    // Output registers.
    logic [rar_pkg::RES_NUM_W-1:0] res_num_reg, res_num_next;
    logic [rar_pkg::RES_DEN_W-1:0] res_den_reg, res_den_next;
    logic                          div_zero_reg, div_zero_next;

    logic [OB-1:0]   nf_u, ns_u;
    logic [OB-1:0]   mul_a, mul_b;
    logic [MW-1:0]   prod;
    logic            s2;
    logic [MW:0]     rem_sh, rem_sub, g_ext;
    logic [EW-1:0]   qn_ext, qd_ext;
    logic [rar_pkg::RES_NUM_W-1:0] num_mag;

    assign nf_u = num_first;
    assign ns_u = num_second;

    // Shared multiplier; operands picked by the command.
    always_comb
    begin
        mul_a = am_reg;
        mul_b = d_reg;
        unique case (ctrl_op)
            rar_pkg::DP_MUL0:
            begin
                mul_a = am_reg;
                mul_b = (op_reg == rar_pkg::OP_MUL) ? cm_reg : d_reg;
            end
            rar_pkg::DP_MUL1:
            begin
                mul_a = cm_reg;
                mul_b = b_reg;
            end
            rar_pkg::DP_MUL2:
            begin
                mul_a = b_reg;
                mul_b = (op_reg == rar_pkg::OP_DIV) ? cm_reg : d_reg;
            end
            default: ;
        endcase
    end

    assign prod = MW'(mul_a) * MW'(mul_b);

    assign s2      = (op_reg == rar_pkg::OP_SUB) ? !cn_reg : cn_reg;
    assign g_ext   = {1'b0, g_reg};
    assign rem_sh  = {rem_reg, sh_reg[MW-1]};
    assign rem_sub = rem_sh - g_ext;
    assign qn_ext  = EW'(qn_reg);
    assign qd_ext  = EW'(qd_reg);

    always_comb
    begin
        if (neg_reg)
        begin
            num_mag = (qn_ext > NEG_LIM) ? 32'h8000_0000 : qn_ext[31:0];
        end
        else
        begin
            num_mag = (qn_ext > POS_LIM) ? 32'h7FFF_FFFF : qn_ext[31:0];
        end
    end

    always_comb
    begin
        op_next       = op_reg;
        am_next       = am_reg;
        cm_next       = cm_reg;
        b_next        = b_reg;
        d_next        = d_reg;
        an_next       = an_reg;
        cn_next       = cn_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        nm_next       = nm_reg;
        dm_next       = dm_reg;
        neg_next      = neg_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        k_next        = k_reg;
        g_next        = g_reg;
        rem_next      = rem_reg;
        sh_next       = sh_reg;
        cnt_next      = cnt_reg;
        qn_next       = qn_reg;
        qd_next       = qd_reg;
        err_next      = err_reg;
        res_num_next  = res_num_reg;
        res_den_next  = res_den_reg;
        div_zero_next = div_zero_reg;

        unique case (ctrl_op)
            rar_pkg::DP_LOAD:
            begin
                op_next = rar_pkg::op_t'(cmd);
                an_next = nf_u[OB-1];
                cn_next = ns_u[OB-1];
                am_next = nf_u[OB-1] ? (~nf_u + OB'(1)) : nf_u;
                cm_next = ns_u[OB-1] ? (~ns_u + OB'(1)) : ns_u;
                b_next  = {1'b0, den_first};
                d_next  = {1'b0, den_second};
            end
            rar_pkg::DP_MUL0: p0_next = prod;
            rar_pkg::DP_MUL1: p1_next = prod;
            rar_pkg::DP_MUL2: p2_next = prod;
            rar_pkg::DP_COMBINE:
            begin
                dm_next = p2_reg;
                unique case (op_reg) inside
                    rar_pkg::OP_ADD, rar_pkg::OP_SUB:
                    begin
                        if (an_reg == s2)
                        begin
                            nm_next  = p0_reg + p1_reg;
                            neg_next = an_reg;
                        end
                        else if (p0_reg >= p1_reg)
                        begin
                            nm_next  = p0_reg - p1_reg;
                            neg_next = an_reg;
                        end
                        else
                        begin
                            nm_next  = p1_reg - p0_reg;
                            neg_next = s2;
                        end
                    end
                    rar_pkg::OP_MUL:
                    begin
                        nm_next  = p0_reg;
                        neg_next = an_reg ^ cn_reg;
                    end
                    default:
                    begin
                        // Divide: the sign of c moves up from the denominator.
                        nm_next  = p0_reg;
                        neg_next = an_reg ^ cn_reg;
                    end
                endcase
            end
            rar_pkg::DP_SET_ERR:
            begin
                qn_next  = '0;
                qd_next  = '0;
                neg_next = 1'b0;
                err_next = 1'b1;
            end
            rar_pkg::DP_SET_ZERO:
            begin
                qn_next  = '0;
                qd_next  = MW'(1);
                neg_next = 1'b0;
                err_next = 1'b0;
            end
            rar_pkg::DP_GCD_INIT:
            begin
                u_next   = nm_reg;
                v_next   = dm_reg;
                k_next   = '0;
                err_next = 1'b0;
            end
            rar_pkg::DP_GCD_TZ:
            begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + CW'(1);
            end
            rar_pkg::DP_GCD_U:
            begin
                u_next = u_reg >> 1;
            end
            rar_pkg::DP_GCD_STEP:
            begin
                // u stays odd; v shrinks until it reaches zero.
                if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_reg > v_reg)
                begin
                    u_next = v_reg;
                    v_next = u_reg - v_reg;
                end
                else
                begin
                    v_next = v_reg - u_reg;
                end
            end
            rar_pkg::DP_GCD_FIX:
            begin
                g_next = u_reg << k_reg;
            end
            rar_pkg::DP_DIV_NUM:
            begin
                rem_next = '0;
                sh_next  = nm_reg;
                cnt_next = '0;
            end
            rar_pkg::DP_DIV_DEN:
            begin
                rem_next = '0;
                sh_next  = dm_reg;
                cnt_next = '0;
            end
            rar_pkg::DP_DIV_STEP:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (rem_sh >= g_ext)
                begin
                    rem_next = rem_sub[MW-1:0];
                    sh_next  = {sh_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[MW-1:0];
                    sh_next  = {sh_reg[MW-2:0], 1'b0};
                end
            end
            rar_pkg::DP_STORE_QN: qn_next = sh_reg;
            rar_pkg::DP_STORE_QD: qd_next = sh_reg;
            rar_pkg::DP_PUSH:
            begin
                res_num_next  = neg_reg ? (~num_mag + 32'd1) : num_mag;
                res_den_next  = (qd_ext > POS_LIM) ? 31'h7FFF_FFFF : qd_ext[30:0];
                div_zero_next = err_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        am_reg       <= am_next;
        cm_reg       <= cm_next;
        b_reg        <= b_next;
        d_reg        <= d_next;
        an_reg       <= an_next;
        cn_reg       <= cn_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        nm_reg       <= nm_next;
        dm_reg       <= dm_next;
        neg_reg      <= neg_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        k_reg        <= k_next;
        g_reg        <= g_next;
        rem_reg      <= rem_next;
        sh_reg       <= sh_next;
        cnt_reg      <= cnt_next;
        qn_reg       <= qn_next;
        qd_reg       <= qd_next;
        err_reg      <= err_next;
        res_num_reg  <= res_num_next;
        res_den_reg  <= res_den_next;
        div_zero_reg <= div_zero_next;
    end

    always_comb
    begin
        dp_stat.dm_zero   = (dm_reg == '0);
        dp_stat.nm_zero   = (nm_reg == '0);
        dp_stat.both_even = !u_reg[0] && !v_reg[0];
        dp_stat.u_even    = !u_reg[0];
        dp_stat.v_zero    = (v_reg == '0);
        dp_stat.div_last  = (cnt_reg == CW'(MW - 1));
    end

    assign res_num  = $signed(res_num_reg);
    assign res_den  = res_den_reg;
    assign div_zero = div_zero_reg;

endmodule

`default_nettype wire

### sv/rar_ctrl.sv
// ----------------------------------------------------------------------------
// rar_ctrl
// Sequencer for the reduce unit: multiply, combine, then gcd and two divisions
// unless the raw numerator or denominator is zero, and the hand-off into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rar_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rar_pkg::dp_op_t          ctrl_op,
    input  wire rar_pkg::dp_stat_t   dp_stat
);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_MULA  = 16'h0002,
        S_MULB  = 16'h0004,
        S_MULC  = 16'h0008,
        S_COMB  = 16'h0010,
        S_CHECK = 16'h0020,
        S_TZ    = 16'h0040,
        S_UODD  = 16'h0080,
        S_LOOP  = 16'h0100,
        S_DIVN  = 16'h0200,
        S_STEPN = 16'h0400,
        S_SAVEN = 16'h0800,
        S_DIVD  = 16'h1000,
        S_STEPD = 16'h2000,
        S_SAVED = 16'h4000,
        S_PUSH  = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl_op    = rar_pkg::DP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl_op    = rar_pkg::DP_LOAD;
                    state_next = S_MULA;
                end
            end
            S_MULA:
            begin
                ctrl_op    = rar_pkg::DP_MUL0;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                ctrl_op    = rar_pkg::DP_MUL1;
                state_next = S_MULC;
            end
            S_MULC:
            begin
                ctrl_op    = rar_pkg::DP_MUL2;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                ctrl_op    = rar_pkg::DP_COMBINE;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (dp_stat.dm_zero)
                begin
                    ctrl_op    = rar_pkg::DP_SET_ERR;
                    state_next = S_PUSH;
                end
                else if (dp_stat.nm_zero)
                begin
                    ctrl_op    = rar_pkg::DP_SET_ZERO;
                    state_next = S_PUSH;
                end
                else
                begin
                    ctrl_op    = rar_pkg::DP_GCD_INIT;
                    state_next = S_TZ;
                end
            end
            S_TZ:
            begin
                if (dp_stat.both_even)
                begin
                    ctrl_op = rar_pkg::DP_GCD_TZ;
                end
                else
                begin
                    state_next = S_UODD;
                end
            end
            S_UODD:
            begin
                if (dp_stat.u_even)
                begin
                    ctrl_op = rar_pkg::DP_GCD_U;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (dp_stat.v_zero)
                begin
                    ctrl_op    = rar_pkg::DP_GCD_FIX;
                    state_next = S_DIVN;
                end
                else
                begin
                    ctrl_op = rar_pkg::DP_GCD_STEP;
                end
            end
            S_DIVN:
            begin
                ctrl_op    = rar_pkg::DP_DIV_NUM;
                state_next = S_STEPN;
            end
            S_STEPN:
            begin
                ctrl_op = rar_pkg::DP_DIV_STEP;
                if (dp_stat.div_last)
                begin
                    state_next = S_SAVEN;
                end
            end
            S_SAVEN:
            begin
                ctrl_op    = rar_pkg::DP_STORE_QN;
                state_next = S_DIVD;
            end
            S_DIVD:
            begin
                ctrl_op    = rar_pkg::DP_DIV_DEN;
                state_next = S_STEPD;
            end
            S_STEPD:
            begin
                ctrl_op = rar_pkg::DP_DIV_STEP;
                if (dp_stat.div_last)
                begin
                    state_next = S_SAVED;
                end
            end
            S_SAVED:
            begin
                ctrl_op    = rar_pkg::DP_STORE_QD;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl_op    = rar_pkg::DP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl_op == rar_pkg::DP_PUSH)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### sv/rational_arith_reduce_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce_unit
// Adds, subtracts, multiplies or divides two fractions and returns the
// result reduced by the greatest common divisor, sign on the numerator.
// ----------------------------------------------------------------------------
//
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_ready  | cmd, num_first, den_first, num_second,
//          |                      | den_second
// output   | out_valid / out_ready| res_num, res_den, div_zero
//
// A zero raw denominator or zero numerator skips the gcd and the divisions;
// any other transaction also strips the common trailing zeros, then the
// further numerator zeros, runs the binary gcd steps and ends with two
// MAG_W-bit restoring divisions, of the numerator and then the denominator.
// Reset clears the sequencer and the output valid flag only. The next input is
// accepted while a result waits; a second finished result stalls until taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rational_arith_reduce_unit_macros.svh"

module rational_arith_reduce_unit (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic [1:0]                               cmd,
    input  wire logic signed [rar_pkg::OPERAND_BITS-1:0]  num_first,
    input  wire logic [rar_pkg::DEN_BITS-1:0]             den_first,
    input  wire logic signed [rar_pkg::OPERAND_BITS-1:0]  num_second,
    input  wire logic [rar_pkg::DEN_BITS-1:0]             den_second,
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic signed [rar_pkg::RES_NUM_W-1:0]          res_num,
    output logic [rar_pkg::RES_DEN_W-1:0]                 res_den,
    output logic                                          div_zero
);

    // Command from the sequencer and status flags back from the datapath.
    rar_pkg::dp_op_t   ctrl_op;
    rar_pkg::dp_stat_t dp_stat;

    // The controller owns the handshakes and steps the datapath through the multiply,
    // combine, gcd and divide phases one command per cycle, stalling before the push while a result waits.
    rar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl_op   (ctrl_op),
        .dp_stat   (dp_stat)
    );

    // The datapath captures the operands on the load command and holds the
    // output register that feeds the result ports.
    rar_datapath u_dp (
        .clk        (clk),
        .ctrl_op    (ctrl_op),
        .dp_stat    (dp_stat),
        .cmd        (cmd),
        .num_first  (num_first),
        .den_first  (den_first),
        .num_second (num_second),
        .den_second (den_second),
        .res_num    (res_num),
        .res_den    (res_den),
        .div_zero   (div_zero)
    );

    // Once a transaction is taken the sequencer is busy on the next cycle.
    `RAR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // An error result carries a zero fraction with a zero denominator.
    `RAR_ASSERT_SAME(a_err_zero_fraction, out_valid && div_zero, res_num == '0 && res_den == '0)
    // A valid result without error always has a positive denominator.
    `RAR_ASSERT_SAME(a_den_nonzero, out_valid && !div_zero, res_den != '0)

endmodule

`default_nettype wire
